// File: sv/lbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// Types and fixed constants shared by the lattice streaming block: word
// layouts, command and status codes, register indexes and the velocity sets.
// ----------------------------------------------------------------------------
package lbs_pkg;

    // Command codes carried in kind
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PROP = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_READ     = 2'd0;
    localparam logic [1:0] STAT_DONE     = 2'd1;
    localparam logic [1:0] STAT_BAD_ADDR = 2'd2;
    localparam logic [1:0] STAT_BAD_GEOM = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SIZE_X     = 3'd0;
    localparam logic [2:0] CFG_SIZE_Y     = 3'd1;
    localparam logic [2:0] CFG_SIZE_Z     = 3'd2;
    localparam logic [2:0] CFG_HALO       = 3'd3;
    localparam logic [2:0] CFG_VEL_SET    = 3'd4;
    localparam logic [2:0] CFG_DIST_COUNT = 3'd5;

    // Velocity counts of D3Q15 and D3Q19
    localparam logic [4:0] VCOUNT_Q15 = 5'd15;
    localparam logic [4:0] VCOUNT_Q19 = 5'd19;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  coord_x;
        logic [3:0]  coord_y;
        logic [3:0]  coord_z;
        logic        dist_sel;
        logic [4:0]  vel_sel;
        logic [63:0] word_in;
    } lbs_in_t;

    typedef struct packed {
        logic [63:0] word_out;
        logic [1:0]  status;
    } lbs_out_t;

    typedef struct packed {
        logic signed [1:0] cx;
        logic signed [1:0] cy;
        logic signed [1:0] cz;
    } vel_vec_t;

    localparam logic signed [1:0] P = 2'sb01;
    localparam logic signed [1:0] Z = 2'sb00;
    localparam logic signed [1:0] N = 2'sb11;

    localparam vel_vec_t VEL15 [15] = '{
        '{Z, Z, Z},
        '{P, P, P}, '{P, P, N}, '{P, Z, Z}, '{P, N, P}, '{P, N, N},
        '{Z, P, Z}, '{Z, Z, P}, '{Z, Z, N}, '{Z, N, Z},
        '{N, P, P}, '{N, P, N}, '{N, Z, Z}, '{N, N, P}, '{N, N, N}
    };

    localparam vel_vec_t VEL19 [19] = '{
        '{Z, Z, Z},
        '{P, P, Z}, '{P, Z, P}, '{P, Z, Z}, '{P, Z, N}, '{P, N, Z},
        '{Z, P, P}, '{Z, P, Z}, '{Z, P, N}, '{Z, Z, P},
        '{Z, Z, N}, '{Z, N, P}, '{Z, N, Z}, '{Z, N, N},
        '{N, P, Z}, '{N, Z, P}, '{N, Z, Z}, '{N, Z, N}, '{N, N, Z}
    };

    function automatic vel_vec_t vel_vec(input logic vset, input logic [4:0] v);
        vel_vec_t c;
        c = '0;
        if (vset) begin
            if (v < VCOUNT_Q19) c = VEL19[v];
        end else begin
            if (v < VCOUNT_Q15) c = VEL15[v[3:0]];
        end
        return c;
    endfunction

endpackage

// File: sv/lbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module lbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/lattice_boltzmann_streaming.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_boltzmann_streaming
// Padded 3D lattice of distribution words with load, read-back and a
// pull-style propagate over every interior site (D3Q15 or D3Q19).
// ----------------------------------------------------------------------------
// All words live in one simple dual-port RAM, so the RAM ports set the pace.
// A load is taken and gives no result; a read is taken and its word appears
// on the result channel after the RAM read data register and then the result
// register. Error results appear the cycle after acceptance. A propagate
// streams one word per cycle through a read/write pipeline: it sweeps every
// velocity but the rest velocity over every interior site and distribution,
// then lets the pipeline drain before its done word; a lattice with an
// empty axis answers at once. Only one command is in flight at a time.
// The lattice RAM has no reset and no clearing pass; a word reads as
// undefined until it has been loaded.
// ----------------------------------------------------------------------------
module lattice_boltzmann_streaming #(
    parameter int MAX_EDGE  = 16,
    parameter int MAX_DIST  = 2,
    parameter int MAX_VEL   = 19,
    parameter int WORD_BITS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lbs_pkg::lbs_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lbs_pkg::lbs_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    import lbs_pkg::*;

    localparam int STRIDE_D = MAX_VEL;
    localparam int STRIDE_Z = MAX_DIST * MAX_VEL;
    localparam int STRIDE_Y = MAX_EDGE * STRIDE_Z;
    localparam int STRIDE_X = MAX_EDGE * STRIDE_Y;
    localparam int DEPTH    = MAX_EDGE * STRIDE_X;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RDWAIT = 2'd1;
    localparam logic [1:0] S_SWEEP  = 2'd2;
    localparam logic [1:0] S_DRAIN  = 2'd3;

    function automatic logic [ADDR_W-1:0] lat_addr(
        input logic [4:0] x,
        input logic [4:0] y,
        input logic [4:0] z,
        input logic       d,
        input logic [4:0] v
    );
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ADDR_W'(x) * ADDR_W'(STRIDE_X))
          + ADDR_W'(ADDR_W'(y) * ADDR_W'(STRIDE_Y))
          + ADDR_W'(ADDR_W'(z) * ADDR_W'(STRIDE_Z))
          + (d ? ADDR_W'(STRIDE_D) : ADDR_W'(0))
          + ADDR_W'(v);
        return a;
    endfunction

    // Configuration
    logic [3:0] size_x_reg, size_y_reg, size_z_reg;
    logic [1:0] halo_reg;
    logic       vset_reg;
    logic [1:0] dcount_reg;

    // Control and pipeline
    logic [1:0]        state_reg, state_next;
    logic [4:0]        v_reg, v_next;
    logic [3:0]        i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic              d_reg, d_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [ADDR_W-1:0] src_addr_reg, src_addr_next;
    logic [ADDR_W-1:0] dst_addr_reg, dst_addr_next;
    logic              p2_valid_reg, p2_valid_next;
    logic [ADDR_W-1:0] dst2_addr_reg, dst2_addr_next;
    logic              m_valid_reg, m_valid_next;
    lbs_out_t          m_data_reg, m_data_next;

    // RAM ports
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic [4:0] ext_x, ext_y, ext_z, vcount;
    logic       geom_ok, addr_ok, empty, s_fire;
    logic [ADDR_W-1:0] in_addr;

    logic       fwd, d_last, k_last, j_last, i_last, v_last;
    vel_vec_t   cvec;
    logic [4:0] hx, cur_x, cur_y, cur_z, src_x, src_y, src_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= 4'd4;
            size_y_reg <= 4'd4;
            size_z_reg <= 4'd4;
            halo_reg   <= 2'd1;
            vset_reg   <= 1'b1;
            dcount_reg <= 2'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SIZE_X:     size_x_reg <= cfg_data[3:0];
                CFG_SIZE_Y:     size_y_reg <= cfg_data[3:0];
                CFG_SIZE_Z:     size_z_reg <= cfg_data[3:0];
                CFG_HALO:       halo_reg   <= cfg_data[1:0];
                CFG_VEL_SET:    vset_reg   <= cfg_data[0];
                CFG_DIST_COUNT: dcount_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Geometry and address checks
    always_comb begin
        hx      = 5'(halo_reg);
        ext_x   = 5'(size_x_reg) + 5'({halo_reg, 1'b0});
        ext_y   = 5'(size_y_reg) + 5'({halo_reg, 1'b0});
        ext_z   = 5'(size_z_reg) + 5'({halo_reg, 1'b0});
        vcount  = vset_reg ? VCOUNT_Q19 : VCOUNT_Q15;
        geom_ok = (halo_reg != 2'd0)
                && (int'(ext_x) <= MAX_EDGE) && (int'(ext_y) <= MAX_EDGE)
                && (int'(ext_z) <= MAX_EDGE)
                && (dcount_reg != 2'd0) && (int'(dcount_reg) <= MAX_DIST)
                && (int'(vcount) <= MAX_VEL);
        addr_ok = (5'(s_data.coord_x) < ext_x) && (5'(s_data.coord_y) < ext_y)
                && (5'(s_data.coord_z) < ext_z)
                && ({1'b0, s_data.dist_sel} < dcount_reg)
                && (s_data.vel_sel < vcount);
        empty   = (size_x_reg == 4'd0) || (size_y_reg == 4'd0) || (size_z_reg == 4'd0);
        in_addr = lat_addr(5'(s_data.coord_x), 5'(s_data.coord_y), 5'(s_data.coord_z),
                           s_data.dist_sel, s_data.vel_sel);
    end

    // Sweep position: forward velocities walk descending so the source stays old
    always_comb begin
        cvec  = vel_vec(vset_reg, v_reg);
        fwd   = (cvec.cx > 0) || ((cvec.cx == 0)
              && ((cvec.cy > 0) || ((cvec.cy == 0) && (cvec.cz > 0))));
        cur_x = fwd ? hx + 5'(size_x_reg) - 5'd1 - 5'(i_reg) : hx + 5'(i_reg);
        cur_y = fwd ? hx + 5'(size_y_reg) - 5'd1 - 5'(j_reg) : hx + 5'(j_reg);
        cur_z = fwd ? hx + 5'(size_z_reg) - 5'd1 - 5'(k_reg) : hx + 5'(k_reg);
        src_x = cur_x - {{3{cvec.cx[1]}}, cvec.cx};
        src_y = cur_y - {{3{cvec.cy[1]}}, cvec.cy};
        src_z = cur_z - {{3{cvec.cz[1]}}, cvec.cz};
        d_last = ({1'b0, d_reg} == dcount_reg - 2'd1);
        k_last = (k_reg == size_z_reg - 4'd1);
        j_last = (j_reg == size_y_reg - 4'd1);
        i_last = (i_reg == size_x_reg - 4'd1);
        v_last = (v_reg == vcount - 5'd1);
    end

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        v_next         = v_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        d_next         = d_reg;
        p1_valid_next  = 1'b0;
        src_addr_next  = src_addr_reg;
        dst_addr_next  = dst_addr_reg;
        p2_valid_next  = p1_valid_reg;
        dst2_addr_next = dst_addr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = dst2_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = src_addr_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire && s_data.kind != 2'd3) begin
                    if (!geom_ok) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{word_out: 64'd0, status: STAT_BAD_GEOM};
                    end else if (s_data.kind == KIND_PROP) begin
                        if (empty) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{word_out: 64'd0, status: STAT_DONE};
                        end else begin
                            state_next = S_SWEEP;
                            v_next     = 5'd1;
                            i_next     = 4'd0;
                            j_next     = 4'd0;
                            k_next     = 4'd0;
                            d_next     = 1'b0;
                        end
                    end else if (!addr_ok) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{word_out: 64'd0, status: STAT_BAD_ADDR};
                    end else if (s_data.kind == KIND_LOAD) begin
                        ram_we    = 1'b1;
                        ram_waddr = in_addr;
                        ram_wdata = s_data.word_in[WORD_BITS-1:0];
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = in_addr;
                        state_next = S_RDWAIT;
                    end
                end
            end
            S_RDWAIT: begin
                m_valid_next = 1'b1;
                m_data_next  = '{word_out: 64'(ram_rdata), status: STAT_READ};
                state_next   = S_IDLE;
            end
            S_SWEEP, S_DRAIN: begin
                // stage 1 reads the source, stage 2 writes the destination
                ram_re = p1_valid_reg;
                ram_we = p2_valid_reg;
                if (state_reg == S_SWEEP) begin
                    p1_valid_next = 1'b1;
                    src_addr_next = lat_addr(src_x, src_y, src_z, d_reg, v_reg);
                    dst_addr_next = lat_addr(cur_x, cur_y, cur_z, d_reg, v_reg);
                    d_next = d_last ? 1'b0 : 1'b1;
                    if (d_last) begin
                        k_next = k_last ? 4'd0 : k_reg + 4'd1;
                        if (k_last) begin
                            j_next = j_last ? 4'd0 : j_reg + 4'd1;
                            if (j_last) begin
                                i_next = i_last ? 4'd0 : i_reg + 4'd1;
                                if (i_last) begin
                                    v_next = v_reg + 5'd1;
                                    if (v_last) state_next = S_DRAIN;
                                end
                            end
                        end
                    end
                end else if (!p1_valid_reg && !p2_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{word_out: 64'd0, status: STAT_DONE};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg         <= v_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        d_reg         <= d_next;
        src_addr_reg  <= src_addr_next;
        dst_addr_reg  <= dst_addr_next;
        dst2_addr_reg <= dst2_addr_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    lbs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_lattice_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// File: tb/sv/tb_lattice_boltzmann_streaming.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_boltzmann_streaming
// Self-checking bench for the lattice streaming block. A behavioural copy of
// the lattice (store, geometry registers, pull-style propagate) predicts
// every answer word; answers are checked in order as they leave the block.
// Directed tests cover the field extremes, error answers and the ignored
// command code. Random phases then reprogram the geometry, preload (within
// a budget) every word a propagate will pull, and mix loads, reads,
// propagates and noise under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_lattice_boltzmann_streaming;
    import lbs_pkg::*;

    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    localparam int EDGE        = 16;
    localparam int DISTS       = 2;
    localparam int VELS        = 19;
    localparam int STORE_WORDS = EDGE * EDGE * EDGE * DISTS * VELS;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int PRELOAD_BUDGET = 600;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    // velocity vectors (x, y, z)
    localparam int VQ15 [15][3] = '{
        '{0, 0, 0},
        '{1, 1, 1}, '{1, 1, -1}, '{1, 0, 0}, '{1, -1, 1}, '{1, -1, -1},
        '{0, 1, 0}, '{0, 0, 1}, '{0, 0, -1}, '{0, -1, 0},
        '{-1, 1, 1}, '{-1, 1, -1}, '{-1, 0, 0}, '{-1, -1, 1}, '{-1, -1, -1}
    };
    localparam int VQ19 [19][3] = '{
        '{0, 0, 0},
        '{1, 1, 0}, '{1, 0, 1}, '{1, 0, 0}, '{1, 0, -1}, '{1, -1, 0},
        '{0, 1, 1}, '{0, 1, 0}, '{0, 1, -1}, '{0, 0, 1},
        '{0, 0, -1}, '{0, -1, 1}, '{0, -1, 0}, '{0, -1, -1},
        '{-1, 1, 0}, '{-1, 0, 1}, '{-1, 0, 0}, '{-1, 0, -1}, '{-1, -1, 0}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    lbs_in_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    lbs_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    // predicted geometry, reset values
    logic [3:0] geo_sx     = 4'd4;
    logic [3:0] geo_sy     = 4'd4;
    logic [3:0] geo_sz     = 4'd4;
    logic [1:0] geo_halo   = 2'd1;
    logic       geo_vset   = 1'b1;
    logic [1:0] geo_dcount = 2'd1;

    logic [63:0] lattice_mem [STORE_WORDS];
    bit          word_set    [STORE_WORDS];

    lbs_out_t answers_due [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int loads_done   = 0;
    int reads_seen   = 0;
    int props_seen   = 0;
    int addr_errs    = 0;
    int geom_errs    = 0;
    int phases_run   = 0;
    int stall_cycles = 0;

    bit       gaps_on    = 1'b0;
    int       burst_left = 1;
    int       rx_mode    = RX_ALWAYS;
    int       hold_seq   = 0;
    int       hold_seen  = 0;
    int       hold_left  = 0;
    bit [7:0] rx_pattern = 8'b1011_0010;

    lattice_boltzmann_streaming i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Lattice predictor
    // ------------------------------------------------------------------------
    function automatic int vel_count();
        return geo_vset ? int'(VCOUNT_Q19) : int'(VCOUNT_Q15);
    endfunction

    function automatic int vel_comp(int v, int axis);
        return geo_vset ? VQ19[v][axis] : VQ15[v][axis];
    endfunction

    function automatic int extent(logic [3:0] sz);
        return int'(sz) + 2 * int'(geo_halo);
    endfunction

    function automatic bit geometry_fits();
        if (geo_halo == 2'd0) return 1'b0;
        if (extent(geo_sx) > EDGE || extent(geo_sy) > EDGE || extent(geo_sz) > EDGE)
            return 1'b0;
        if (geo_dcount == 2'd0 || int'(geo_dcount) > DISTS) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit address_fits(lbs_in_t it);
        return int'(it.coord_x) < extent(geo_sx) && int'(it.coord_y) < extent(geo_sy) &&
               int'(it.coord_z) < extent(geo_sz) && int'(it.dist_sel) < int'(geo_dcount) &&
               int'(it.vel_sel) < vel_count();
    endfunction

    function automatic int word_index(int x, int y, int z, int d, int v);
        return (((x * EDGE + y) * EDGE + z) * DISTS + d) * VELS + v;
    endfunction

    // true when every word a propagate would pull has been written
    function automatic bit sources_ready();
        int h, v, x, y, z, d;
        h = int'(geo_halo);
        for (v = 1; v < vel_count(); v++)
            for (x = h; x < h + int'(geo_sx); x++)
                for (y = h; y < h + int'(geo_sy); y++)
                    for (z = h; z < h + int'(geo_sz); z++)
                        for (d = 0; d < int'(geo_dcount); d++)
                            if (!word_set[word_index(x - vel_comp(v, 0), y - vel_comp(v, 1),
                                                     z - vel_comp(v, 2), d, v)])
                                return 1'b0;
        return 1'b1;
    endfunction

    // pull every interior word from its upstream neighbour, all reads first
    function automatic void stream_lattice();
        int h, v, x, y, z, d;
        int dst_q [$];
        logic [63:0] val_q [$];
        h = int'(geo_halo);
        for (v = 1; v < vel_count(); v++)
            for (x = h; x < h + int'(geo_sx); x++)
                for (y = h; y < h + int'(geo_sy); y++)
                    for (z = h; z < h + int'(geo_sz); z++)
                        for (d = 0; d < int'(geo_dcount); d++) begin
                            dst_q.push_back(word_index(x, y, z, d, v));
                            val_q.push_back(lattice_mem[word_index(x - vel_comp(v, 0),
                                y - vel_comp(v, 1), z - vel_comp(v, 2), d, v)]);
                        end
        foreach (dst_q[i]) begin
            lattice_mem[dst_q[i]] = val_q[i];
            word_set[dst_q[i]]    = 1'b1;
        end
    endfunction

    function automatic bit lattice_step(input lbs_in_t it, output lbs_out_t res);
        int idx;
        res = '0;
        if (it.kind == KIND_NONE) return 1'b0;
        if (!geometry_fits()) begin
            res.status = STAT_BAD_GEOM;
            return 1'b1;
        end
        if (it.kind == KIND_PROP) begin
            stream_lattice();
            res.status = STAT_DONE;
            return 1'b1;
        end
        if (!address_fits(it)) begin
            res.status = STAT_BAD_ADDR;
            return 1'b1;
        end
        idx = word_index(it.coord_x, it.coord_y, it.coord_z, it.dist_sel, it.vel_sel);
        if (it.kind == KIND_LOAD) begin
            lattice_mem[idx] = it.word_in;
            word_set[idx]    = 1'b1;
            loads_done++;
            return 1'b0;
        end
        res.word_out = lattice_mem[idx];
        res.status   = STAT_READ;
        return 1'b1;
    endfunction

    // never read unwritten words: such reads become loads, such propagates reads
    function automatic lbs_in_t legalise(lbs_in_t it);
        if (!geometry_fits()) return it;
        if (it.kind == KIND_PROP && !sources_ready()) it.kind = KIND_READ;
        if (it.kind == KIND_READ && address_fits(it) &&
            !word_set[word_index(it.coord_x, it.coord_y, it.coord_z, it.dist_sel, it.vel_sel)])
            it.kind = KIND_LOAD;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------------
    function automatic lbs_in_t cmd(logic [1:0] kind, int x, int y, int z, int d, int v,
                                    logic [63:0] w);
        lbs_in_t it;
        it.kind     = kind;
        it.coord_x  = 4'(x);
        it.coord_y  = 4'(y);
        it.coord_z  = 4'(z);
        it.dist_sel = 1'(d);
        it.vel_sel  = 5'(v);
        it.word_in  = w;
        return it;
    endfunction

    function automatic lbs_in_t random_fields();
        return cmd(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 31),
                   {$urandom, $urandom});
    endfunction

    // near: stay within the interior plus one layer, where preloaded words live
    function automatic int pick_coord(logic [3:0] sz, bit near);
        int lim, h;
        h   = int'(geo_halo);
        lim = extent(sz);
        if (lim > EDGE) lim = EDGE;
        if (lim < 1) lim = 1;
        if (near && geometry_fits()) begin
            if (h + int'(sz) < lim - 1)
                return $urandom_range(h - 1, h + int'(sz));
            return $urandom_range(h - 1, lim - 1);
        end
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic lbs_in_t valid_item(logic [1:0] kind, bit near);
        lbs_in_t it;
        it          = random_fields();
        it.kind     = kind;
        it.coord_x  = 4'(pick_coord(geo_sx, near));
        it.coord_y  = 4'(pick_coord(geo_sy, near));
        it.coord_z  = 4'(pick_coord(geo_sz, near));
        it.vel_sel  = 5'($urandom_range(0, vel_count() - 1));
        if (geo_dcount == 2'd1) it.dist_sel = 1'b0;
        return it;
    endfunction

    function automatic lbs_in_t bad_address_item();
        lbs_in_t it;
        bit broke;
        it    = valid_item($urandom_range(0, 1) ? KIND_LOAD : KIND_READ, 1'b0);
        broke = 1'b0;
        if (extent(geo_sx) < EDGE && $urandom_range(0, 2) == 0) begin
            it.coord_x = 4'($urandom_range(extent(geo_sx), 15));
            broke = 1'b1;
        end
        if (extent(geo_sy) < EDGE && $urandom_range(0, 2) == 0) begin
            it.coord_y = 4'($urandom_range(extent(geo_sy), 15));
            broke = 1'b1;
        end
        if (extent(geo_sz) < EDGE && $urandom_range(0, 2) == 0) begin
            it.coord_z = 4'($urandom_range(extent(geo_sz), 15));
            broke = 1'b1;
        end
        if (geo_dcount == 2'd1 && $urandom_range(0, 2) == 0) begin
            it.dist_sel = 1'b1;
            broke = 1'b1;
        end
        if (!broke || $urandom_range(0, 2) == 0)
            it.vel_sel = 5'($urandom_range(vel_count(), 31));
        return it;
    endfunction

    function automatic lbs_in_t make_item();
        lbs_in_t it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      it = valid_item(KIND_READ, 1'b1);
        else if (r < 68) it = valid_item(KIND_LOAD, 1'($urandom_range(0, 1)));
        else if (r < 78) it = valid_item(KIND_PROP, 1'b0);
        else if (r < 92) it = bad_address_item();
        else begin
            it = random_fields();
            if (r < 95) it.kind = KIND_NONE;
            else        it.kind = 2'($urandom_range(0, 2));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    task automatic push_cmd(input lbs_in_t raw);
        lbs_in_t  it;
        lbs_out_t res;
        it = legalise(raw);
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (lattice_step(it, res)) answers_due.push_back(res);
        if (it.kind != KIND_NONE) items_sent++;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // wait for every answer, then let a trailing load retire
    task automatic settle();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        logic [7:0] mask, data;
        case (idx)
            CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z: mask = 8'h0f;
            CFG_HALO, CFG_DIST_COUNT:           mask = 8'h03;
            CFG_VEL_SET:                        mask = 8'h01;
            default:                            mask = 8'h00;
        endcase
        // unused upper bits carry junk
        data = (8'($urandom) & ~mask) | (8'(val) & mask);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_SIZE_X:     geo_sx     = data[3:0];
            CFG_SIZE_Y:     geo_sy     = data[3:0];
            CFG_SIZE_Z:     geo_sz     = data[3:0];
            CFG_HALO:       geo_halo   = data[1:0];
            CFG_VEL_SET:    geo_vset   = data[0];
            CFG_DIST_COUNT: geo_dcount = data[1:0];
            default: ;
        endcase
    endtask

    task automatic program_geometry(input int sx, input int sy, input int sz, input int h,
                                    input int vs, input int dc);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        write_reg(CFG_HALO, h);
        write_reg(CFG_VEL_SET, vs);
        write_reg(CFG_DIST_COUNT, dc);
        cfg_valid <= 1'b0;
    endtask

    // load every not yet written word that a propagate will pull
    task automatic preload_sources();
        int h, v, x, y, z, d;
        h = int'(geo_halo);
        for (v = 1; v < vel_count(); v++)
            for (x = h; x < h + int'(geo_sx); x++)
                for (y = h; y < h + int'(geo_sy); y++)
                    for (z = h; z < h + int'(geo_sz); z++)
                        for (d = 0; d < int'(geo_dcount); d++)
                            if (!word_set[word_index(x - vel_comp(v, 0), y - vel_comp(v, 1),
                                                     z - vel_comp(v, 2), d, v)])
                                push_cmd(cmd(KIND_LOAD, x - vel_comp(v, 0), y - vel_comp(v, 1),
                                             z - vel_comp(v, 2), d, v, {$urandom, $urandom}));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_load_read_defaults();
        push_cmd(cmd(KIND_LOAD, 0, 0, 0, 0, 0, '1));
        push_cmd(cmd(KIND_LOAD, 5, 5, 5, 0, 18, '0));
        push_cmd(cmd(KIND_READ, 0, 0, 0, 0, 0, '0));
        push_cmd(cmd(KIND_READ, 5, 5, 5, 0, 18, '1));
    endtask

    task automatic test_bad_address();
        push_cmd(cmd(KIND_READ, 6, 1, 1, 0, 1, '0));
        push_cmd(cmd(KIND_LOAD, 1, 15, 1, 0, 1, '1));
        push_cmd(cmd(KIND_READ, 1, 1, 15, 0, 1, '0));
        push_cmd(cmd(KIND_READ, 1, 1, 1, 1, 1, '0));
        push_cmd(cmd(KIND_LOAD, 1, 1, 1, 0, 19, '1));
        push_cmd(cmd(KIND_READ, 1, 1, 1, 0, 31, '0));
    endtask

    task automatic test_ignored_inputs();
        push_cmd(cmd(KIND_NONE, 15, 15, 15, 1, 31, '1));
        settle();
        write_reg(CFG_UNUSED, 0);
        cfg_valid <= 1'b0;
        push_cmd(cmd(KIND_READ, 0, 0, 0, 0, 0, '0));
    endtask

    task automatic test_empty_interior();
        settle();
        program_geometry(0, 4, 4, 1, 1, 1);
        push_cmd(cmd(KIND_PROP, 0, 0, 0, 0, 0, '0));
        push_cmd(cmd(KIND_LOAD, 1, 0, 0, 0, 3, 64'h8000_0000_0000_0001));
        push_cmd(cmd(KIND_READ, 1, 0, 0, 0, 3, '0));
    endtask

    task automatic test_bad_geometry();
        settle();
        program_geometry(4, 4, 4, 0, 1, 1);
        push_cmd(cmd(KIND_LOAD, 1, 1, 1, 0, 1, '1));
        push_cmd(cmd(KIND_READ, 0, 0, 0, 0, 0, '0));
        push_cmd(cmd(KIND_PROP, 0, 0, 0, 0, 0, '0));
        settle();
        program_geometry(4, 4, 4, 1, 1, 0);
        push_cmd(cmd(KIND_READ, 0, 0, 0, 0, 0, '0));
        settle();
        program_geometry(4, 4, 4, 1, 1, 3);
        push_cmd(cmd(KIND_LOAD, 2, 2, 2, 0, 2, '1));
        settle();
        program_geometry(15, 4, 4, 1, 1, 1);
        push_cmd(cmd(KIND_READ, 0, 0, 0, 0, 0, '0));
        settle();
        program_geometry(11, 4, 4, 3, 0, 1);
        push_cmd(cmd(KIND_PROP, 0, 0, 0, 0, 0, '0));
    endtask

    // receiver holds off while reads keep coming, so the input must stall
    task automatic test_backpressure();
        settle();
        program_geometry(1, 1, 1, 1, 1, 1);
        preload_sources();
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        hold_seq++;
        repeat (30) push_cmd(valid_item(KIND_READ, 1'b1));
        settle();
    endtask

    task automatic test_random_phases();
        int target, sel, span, sx, sy, sz, h, vs, dc, count;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            sel = $urandom_range(0, 10);
            vs  = $urandom_range(0, 1);
            dc  = $urandom_range(1, 2);
            h   = 1;
            sx  = 1;
            sy  = 1;
            sz  = 1;
            if (sel <= 5) begin
                sx = $urandom_range(1, 2);
                sy = $urandom_range(1, 2);
                sz = (sx * sy <= 2) ? $urandom_range(1, 2) : 1;
                h  = $urandom_range(1, 3);
            end else if (sel == 6) begin
                // one long axis
                span = $urandom_range(8, 14);
                case ($urandom_range(0, 2))
                    0: sx = span;
                    1: sy = span;
                    default: sz = span;
                endcase
            end else if (sel == 7) begin
                // full 16-site extent: loads and reads only
                sx = 14;
                sy = 14;
                sz = 14;
            end else if (sel == 8) begin
                sx = $urandom_range(0, 2);
                sy = $urandom_range(0, 2);
                sz = (sx != 0 && sy != 0) ? 0 : $urandom_range(0, 2);
                h  = $urandom_range(1, 3);
            end else begin
                case ($urandom_range(0, 3))
                    0: h = 0;
                    1: dc = 0;
                    2: dc = 3;
                    default: begin
                        h  = $urandom_range(1, 3);
                        sx = $urandom_range(17 - 2 * h, 15);
                    end
                endcase
            end
            settle();
            program_geometry(sx, sy, sz, h, vs, dc);
            rx_mode    = $urandom_range(RX_ALWAYS, RX_PATTERN);
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 24);
            if (geometry_fits() &&
                (vel_count() - 1) * sx * sy * sz * dc <= PRELOAD_BUDGET)
                preload_sources();
            count = geometry_fits() ? $urandom_range(40, 90) : $urandom_range(10, 20);
            repeat (count) begin
                push_cmd(make_item());
                if ($urandom_range(0, 49) == 0) settle();
            end
            phases_run++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver, checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM:  m_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: begin
                    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
                    m_ready <= rx_pattern[0];
                end
                default:    m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        lbs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 200)
                    $display("%0t: unexpected word: word_out %h status %0d", $time,
                             m_data.word_out, m_data.status);
            end else begin
                want = answers_due.pop_front();
                if (m_data.word_out !== want.word_out) begin
                    fail_count++;
                    if (fail_count <= 200)
                        $display("%0t: word_out mismatch: expected %h, got %h", $time,
                                 want.word_out, m_data.word_out);
                end
                if (m_data.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 200)
                        $display("%0t: status mismatch: expected %0d, got %0d", $time,
                                 want.status, m_data.status);
                end
                case (want.status)
                    STAT_READ:     reads_seen++;
                    STAT_DONE:     props_seen++;
                    STAT_BAD_ADDR: addr_errs++;
                    default:       geom_errs++;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d words outstanding", $time,
                     stall_cycles, answers_due.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_load_read_defaults();
        test_bad_address();
        test_ignored_inputs();
        test_empty_interior();
        test_bad_geometry();
        test_backpressure();
        test_random_phases();
        settle();
        repeat (END_CYCLES) @(posedge aclk);
        $display("Sent %0d commands over %0d random geometries: %0d loads, %0d reads checked,",
                 items_sent, phases_run, loads_done, reads_seen);
        $display("%0d propagates, %0d bad-address and %0d bad-geometry answers.",
                 props_seen, addr_errs, geom_errs);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
